// ===== rtl/ema_pkg.sv =====
package ema_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned NUM_W     = 49;
  localparam int unsigned MAG_W     = 48;
  localparam int unsigned DIV_STEPS = 48;
  localparam int unsigned CNT_W     = 6;

  localparam logic REG_SCALE      = 1'b0;
  localparam logic REG_ALPHA      = 1'b1;
  localparam logic ACT_FILTER     = 1'b0;
  localparam logic ACT_CLEAR      = 1'b1;
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MUL_A,
    ST_MUL_B,
    ST_ADD,
    ST_ABS,
    ST_DIV,
    ST_FIN,
    ST_RESULT
  } ema_state_t;

  typedef struct packed {
    logic capture;
    logic clear;
    logic prime;
    logic invalid;
    logic mul_a;
    logic mul_b;
    logic add;
    logic absval;
    logic div_step;
    logic finish;
    logic emit;
  } ema_cmd_t;

  typedef struct packed {
    logic clear_req;
    logic cfg_ok;
    logic primed;
    logic div_last;
    logic out_busy;
  } ema_stat_t;

endpackage

// ===== rtl/ema_ctrl.sv =====
module ema_ctrl import ema_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  ema_stat_t stat,
  output ema_cmd_t  cmd
);

  ema_state_t state_r, state_nxt;
  logic       accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (stat.clear_req) begin
          cmd.clear = 1'b1;
          state_nxt = ST_RESULT;
        end else if (!stat.cfg_ok) begin
          cmd.invalid = 1'b1;
          state_nxt   = ST_RESULT;
        end else if (!stat.primed) begin
          cmd.prime = 1'b1;
          state_nxt = ST_RESULT;
        end else begin
          state_nxt = ST_MUL_A;
        end
      end
      ST_MUL_A: begin
        cmd.mul_a = 1'b1;
        state_nxt = ST_MUL_B;
      end
      ST_MUL_B: begin
        cmd.mul_b = 1'b1;
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = ST_ABS;
      end
      ST_ABS: begin
        cmd.absval = 1'b1;
        state_nxt  = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_RESULT;
      end
      ST_RESULT: begin
        if (!stat.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_accept_decide: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_DECIDE)
    else $error("accepted beat did not move to decide");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !stat.out_busy)
    else $error("result loaded while output register busy");

  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && stat.div_last) |=> state_r == ST_FIN)
    else $error("divider did not finish after last step");

endmodule

// ===== rtl/ema_datapath.sv =====
module ema_datapath import ema_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  ema_cmd_t          cmd,
  output ema_stat_t         stat,
  input  logic              in_action,
  input  logic [DATA_W-1:0] in_sample,
  input  logic [CFG_W-1:0]  scale,
  input  logic [CFG_W-1:0]  alpha,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_filtered,
  output logic              out_status
);

  logic                     action_r;
  logic signed [DATA_W-1:0] sample_r;
  logic signed [DATA_W-1:0] avg_r, avg_nxt;
  logic                     primed_r, primed_nxt;
  logic                     status_r;
  logic signed [NUM_W-1:0]  prod_a_r, prod_b_r, num_r;
  logic [MAG_W-1:0]         quo_r, quo_nxt;
  logic [CFG_W-1:0]         rem_r, rem_nxt;
  logic                     neg_r;
  logic [CNT_W-1:0]         cnt_r;
  logic                     out_valid_r;
  logic [DATA_W-1:0]        out_filtered_r;
  logic                     out_status_r;

  logic [CFG_W-1:0]         weight;
  logic [CFG_W:0]           trial;
  logic [CFG_W:0]           diff;
  logic                     fits;
  logic [DATA_W-1:0]        quo_lo;

  assign weight = scale - alpha;

  assign stat.clear_req = (action_r == ACT_CLEAR);
  assign stat.cfg_ok    = (scale != '0) && (alpha != '0) && (alpha <= scale);
  assign stat.primed    = primed_r;
  assign stat.div_last  = (cnt_r == CNT_W'(DIV_STEPS - 1));
  assign stat.out_busy  = out_valid_r && !out_ready;

  // restoring divide, one quotient bit per step
  assign trial   = {rem_r, quo_r[MAG_W-1]};
  assign diff    = trial - {1'b0, scale};
  assign fits    = (trial >= {1'b0, scale});
  assign rem_nxt = fits ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
  assign quo_nxt = {quo_r[MAG_W-2:0], fits};
  assign quo_lo  = quo_r[DATA_W-1:0];

  always_comb begin
    avg_nxt    = avg_r;
    primed_nxt = primed_r;
    if (cmd.clear) begin
      avg_nxt    = '0;
      primed_nxt = 1'b0;
    end else if (cmd.prime) begin
      avg_nxt    = sample_r;
      primed_nxt = 1'b1;
    end else if (cmd.finish) begin
      avg_nxt = neg_r ? $signed(-quo_lo) : $signed(quo_lo);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r       <= '0;
      primed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      avg_r    <= avg_nxt;
      primed_r <= primed_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      action_r <= in_action;
      sample_r <= $signed(in_sample);
      status_r <= STATUS_OK;
    end
    if (cmd.invalid) begin
      status_r <= STATUS_INVALID;
    end
    if (cmd.mul_a) begin
      prod_a_r <= $signed({1'b0, alpha}) * sample_r;
    end
    if (cmd.mul_b) begin
      prod_b_r <= $signed({1'b0, weight}) * avg_r;
    end
    if (cmd.add) begin
      num_r <= prod_a_r + prod_b_r;
    end
    if (cmd.absval) begin
      neg_r <= num_r[NUM_W-1];
      quo_r <= num_r[NUM_W-1] ? MAG_W'(-num_r) : num_r[MAG_W-1:0];
      rem_r <= '0;
      cnt_r <= '0;
    end
    if (cmd.div_step) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.emit) begin
      out_filtered_r <= avg_r;
      out_status_r   <= status_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_filtered = out_filtered_r;
  assign out_status   = out_status_r;

endmodule

// ===== rtl/ema_filter_unit.sv =====
// Exponential moving average of signed 32-bit samples. Each input beat either
// clears the filter (tuser high) or filters tdata; each gives one result beat
// with the new average in tdata and an invalid-configuration flag in tuser.
// The first sample after a clear or reset is taken as the average unchanged.
// A filtering beat runs a decide step, both multiplies, an add and sign
// handling, then the 48-step restoring divider that yields one quotient bit
// per cycle, then a final sign fix; clear, priming and invalid-configuration
// beats go from decide straight to the result. One beat is in work at a time;
// the next is accepted while the previous result waits in the output
// register. Write scale and alpha only while the block is idle.
module ema_filter_unit import ema_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,   // [31:0] sample
  input  logic              in_tuser,   // [0] action
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,  // [31:0] filtered
  output logic              out_tuser,  // [0] status
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  logic [CFG_W-1:0] scale_r;
  logic [CFG_W-1:0] alpha_r;
  ema_cmd_t         cmd;
  ema_stat_t        stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= CFG_W'(16);
      alpha_r <= CFG_W'(4);
    end else if (cfg_we) begin
      if (cfg_index == REG_SCALE) begin
        scale_r <= cfg_wdata;
      end else if (cfg_index == REG_ALPHA) begin
        alpha_r <= cfg_wdata;
      end
    end
  end

  ema_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ema_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_action    (in_tuser),
    .in_sample    (in_tdata),
    .scale        (scale_r),
    .alpha        (alpha_r),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_filtered (out_tdata),
    .out_status   (out_tuser)
  );

endmodule
